FILE: hdl/wpet_pkg.sv
// ----------------------------------------------------------------------------
// wpet_pkg
// Shared types and constants for the window peak exposure tracker.
// ----------------------------------------------------------------------------
package wpet_pkg;

   localparam int NUM_CH     = 3;
   localparam int LEVEL_W    = 16;   // Q8.8 pixel channel
   localparam int SMOOTH_W   = 24;   // Q8.16 adapted peak
   localparam int CFG_DIM_W  = 13;
   localparam int HALF_W     = 8;
   localparam int RATE_W     = 16;   // Q0.16
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // peak << 8 minus adapted peak, signed
   localparam int DIFF_W     = SMOOTH_W + 1;
   localparam int PROD_W     = DIFF_W + RATE_W + 1;
   localparam int DELTA_W    = PROD_W - RATE_W;
   localparam int SUM_W      = SMOOTH_W + 3;

   typedef logic [LEVEL_W-1:0]   level_type;
   typedef logic [SMOOTH_W-1:0]  smooth_type;
   typedef logic [CFG_DIM_W-1:0] dim_cfg_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_WINDOW_CENTER_U = 3'd2,
      CSR_WINDOW_CENTER_V = 3'd3,
      CSR_WINDOW_HALF     = 3'd4,
      CSR_SMOOTHING_RATE  = 3'd5,
      CSR_TRACKING_ENABLE = 3'd6
   } csr_index_type;

   localparam dim_cfg_type        RST_IMAGE_WIDTH  = 13'd1024;
   localparam dim_cfg_type        RST_IMAGE_HEIGHT = 13'd768;
   localparam dim_cfg_type        RST_CENTER_U     = 13'd512;
   localparam dim_cfg_type        RST_CENTER_V     = 13'd384;
   localparam logic [HALF_W-1:0]  RST_HALF_SIZE    = 8'd25;
   localparam logic [RATE_W-1:0]  RST_RATE         = 16'd655;   // ~0.01 in Q0.16

   localparam smooth_type SMOOTH_MAX = {SMOOTH_W{1'b1}};

endpackage

FILE: hdl/window_peak_exposure_tracker_core.sv
// ----------------------------------------------------------------------------
// window_peak_exposure_tracker_core
// Region-maximum auto exposure: per-channel window peak with IIR smoothing.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock. Pixels inside the clipped square window
// update per-channel running maxima in the same cycle they are accepted, so
// the steady rate is one pixel per cycle. The last pixel of a frame (with
// tracking enabled) launches the peak adaptation: the three 25x17 signed
// multiplies are registered, then the add and saturate go into the result
// register, which happens as soon as that register is free. While an
// adaptation is still in flight, only a pixel that would end a tracked frame
// is stalled; other pixels keep flowing. There is no start-up clearing pass.
module window_peak_exposure_tracker_core
   import wpet_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  level_type             req_red_level,
   input  level_type             req_green_level,
   input  level_type             req_blue_level,
   input  logic                  req_first_of_frame,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output smooth_type            rsp_smooth_red,
   output smooth_type            rsp_smooth_green,
   output smooth_type            rsp_smooth_blue,
   output level_type             rsp_frame_peak_red,
   output level_type             rsp_frame_peak_green,
   output level_type             rsp_frame_peak_blue
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = (CNT_W + 1 > CFG_DIM_W) ? CNT_W + 1 : CFG_DIM_W;

   // configuration
   dim_cfg_type        width_cfg_ff, height_cfg_ff, center_u_ff, center_v_ff;
   logic [HALF_W-1:0]  half_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic               track_en_ff;

   // frame state
   logic [CNT_W-1:0]   col_ff, row_ff;
   level_type          peak_ff [NUM_CH];
   smooth_type         adapted_ff [NUM_CH];

   // adaptation pipeline
   logic               mul_go_ff;
   level_type          fin_peak_ff [NUM_CH];
   logic               prod_vld_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_CH];

   // result register
   logic               rsp_valid_ff;
   smooth_type         rsp_smooth_ff [NUM_CH];
   level_type          rsp_peak_ff [NUM_CH];

   // ---------------------------------------------------------------------
   // Pixel path
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0]   w_eff, h_eff, col_cur, row_cur, cu, cv, du, dv;
   level_type          px [NUM_CH];
   level_type          peak_cur [NUM_CH];
   level_type          peak_in [NUM_CH];
   logic               in_window, row_end, frame_end, req_take, end_tracked;

   always_comb begin
      if (width_cfg_ff == '0)
         w_eff = DIM_W'(1);
      else if (DIM_W'(width_cfg_ff) > DIM_W'(MAX_DIM))
         w_eff = DIM_W'(MAX_DIM);
      else
         w_eff = DIM_W'(width_cfg_ff);

      if (height_cfg_ff == '0)
         h_eff = DIM_W'(1);
      else if (DIM_W'(height_cfg_ff) > DIM_W'(MAX_DIM))
         h_eff = DIM_W'(MAX_DIM);
      else
         h_eff = DIM_W'(height_cfg_ff);

      col_cur = req_first_of_frame ? '0 : DIM_W'(col_ff);
      row_cur = req_first_of_frame ? '0 : DIM_W'(row_ff);
      cu      = DIM_W'(center_u_ff);
      cv      = DIM_W'(center_v_ff);
      du      = (col_cur >= cu) ? col_cur - cu : cu - col_cur;
      dv      = (row_cur >= cv) ? row_cur - cv : cv - row_cur;

      in_window = (col_cur < w_eff) && (row_cur < h_eff) &&
                  (du <= DIM_W'(half_ff)) && (dv <= DIM_W'(half_ff));

      px[0] = req_red_level;
      px[1] = req_green_level;
      px[2] = req_blue_level;
      for (int c = 0; c < NUM_CH; c++) begin
         peak_cur[c] = req_first_of_frame ? '0 : peak_ff[c];
         peak_in[c]  = (in_window && px[c] > peak_cur[c]) ? px[c] : peak_cur[c];
      end

      row_end     = (col_cur + DIM_W'(1)) >= w_eff;
      frame_end   = row_end && ((row_cur + DIM_W'(1)) >= h_eff);
      end_tracked = frame_end && track_en_ff;
   end

   // a tracked frame-ending pixel waits until the previous adaptation has landed
   assign req_stall = (mul_go_ff || prod_vld_ff) && end_tracked;
   assign req_take  = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Adaptation: multiply, then add/saturate into the result register
   // ---------------------------------------------------------------------
   logic signed [DIFF_W-1:0]  diff [NUM_CH];
   logic signed [PROD_W-1:0]  prod_in [NUM_CH];
   logic signed [DELTA_W-1:0] delta [NUM_CH];
   logic signed [SUM_W-1:0]   sum [NUM_CH];
   smooth_type                adapt_in [NUM_CH];
   logic signed [RATE_W:0]    rate_s;
   logic                      rsp_free, rsp_load;

   always_comb begin
      rate_s = $signed({1'b0, rate_ff});
      for (int c = 0; c < NUM_CH; c++) begin
         diff[c]    = $signed({1'b0, fin_peak_ff[c], 8'h00}) -
                      $signed({1'b0, adapted_ff[c]});
         prod_in[c] = diff[c] * rate_s;
         // arithmetic shift floors negative steps
         delta[c]   = DELTA_W'(prod_ff[c] >>> RATE_W);
         sum[c]     = $signed({3'b000, adapted_ff[c]}) + SUM_W'(delta[c]);
         if (sum[c] < 0)
            adapt_in[c] = '0;
         else if (sum[c] > $signed({3'b000, SMOOTH_MAX}))
            adapt_in[c] = SMOOTH_MAX;
         else
            adapt_in[c] = sum[c][SMOOTH_W-1:0];
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = prod_vld_ff && rsp_free;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= RST_IMAGE_WIDTH;
         height_cfg_ff <= RST_IMAGE_HEIGHT;
         center_u_ff   <= RST_CENTER_U;
         center_v_ff   <= RST_CENTER_V;
         half_ff       <= RST_HALF_SIZE;
         rate_ff       <= RST_RATE;
         track_en_ff   <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:     width_cfg_ff  <= csr_write_data[CFG_DIM_W-1:0];
            CSR_IMAGE_HEIGHT:    height_cfg_ff <= csr_write_data[CFG_DIM_W-1:0];
            CSR_WINDOW_CENTER_U: center_u_ff   <= csr_write_data[CFG_DIM_W-1:0];
            CSR_WINDOW_CENTER_V: center_v_ff   <= csr_write_data[CFG_DIM_W-1:0];
            CSR_WINDOW_HALF:     half_ff       <= csr_write_data[HALF_W-1:0];
            CSR_SMOOTHING_RATE:  rate_ff       <= csr_write_data[RATE_W-1:0];
            CSR_TRACKING_ENABLE: track_en_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         mul_go_ff <= 1'b0;
         for (int c = 0; c < NUM_CH; c++)
            peak_ff[c] <= '0;
      end else begin
         mul_go_ff <= req_take && end_tracked;
         if (req_take) begin
            if (!row_end) begin
               col_ff <= CNT_W'(col_cur + DIM_W'(1));
               row_ff <= CNT_W'(row_cur);
            end else if (!frame_end) begin
               col_ff <= '0;
               row_ff <= CNT_W'(row_cur + DIM_W'(1));
            end else begin
               col_ff <= '0;
               row_ff <= '0;
            end
            for (int c = 0; c < NUM_CH; c++)
               peak_ff[c] <= frame_end ? '0 : peak_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && end_tracked) begin
         for (int c = 0; c < NUM_CH; c++)
            fin_peak_ff[c] <= peak_in[c];
      end
      if (mul_go_ff) begin
         for (int c = 0; c < NUM_CH; c++)
            prod_ff[c] <= prod_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CH; c++)
            adapted_ff[c] <= '0;
      end else begin
         if (mul_go_ff)
            prod_vld_ff <= 1'b1;
         else if (rsp_load)
            prod_vld_ff <= 1'b0;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            for (int c = 0; c < NUM_CH; c++)
               adapted_ff[c] <= adapt_in[c];
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int c = 0; c < NUM_CH; c++) begin
            rsp_smooth_ff[c] <= adapt_in[c];
            rsp_peak_ff[c]   <= fin_peak_ff[c];
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_smooth_red       = rsp_smooth_ff[0];
   assign rsp_smooth_green     = rsp_smooth_ff[1];
   assign rsp_smooth_blue      = rsp_smooth_ff[2];
   assign rsp_frame_peak_red   = rsp_peak_ff[0];
   assign rsp_frame_peak_green = rsp_peak_ff[1];
   assign rsp_frame_peak_blue  = rsp_peak_ff[2];

endmodule
